[hdl/four_channel_counter_timer_core_defines.svh]
// ----------------------------------------------------------------------------
// Four-channel counter/timer core: assertion macros
// Shared property wrappers for the checker.
// ----------------------------------------------------------------------------
`ifndef FOUR_CHANNEL_COUNTER_TIMER_CORE_DEFINES_SVH
`define FOUR_CHANNEL_COUNTER_TIMER_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define FCCT_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fcct assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define FCCT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("fcct assertion failed");

`endif

[hdl/fcct_pkg.sv]
// ----------------------------------------------------------------------------
// fcct_pkg
// Command codes, control word bits and channel interface types.
// ----------------------------------------------------------------------------
package fcct_pkg;

	localparam int NUM_CH = 4;

	localparam logic [1:0] CMD_TICK  = 2'd0;
	localparam logic [1:0] CMD_READ  = 2'd1;
	localparam logic [1:0] CMD_WRITE = 2'd2;
	localparam logic [1:0] CMD_ACK   = 2'd3;

	localparam int CW_IS_CONTROL   = 0;
	localparam int CW_SOFT_RESET   = 1;
	localparam int CW_TC_FOLLOWS   = 2;
	localparam int CW_PRESCALE256  = 5;
	localparam int CW_COUNTER_MODE = 6;
	localparam int CW_INT_ENABLE   = 7;

	localparam logic [15:0] ACCUM_MAX   = 16'hFFFF;
	localparam logic [15:0] PERIOD_16   = 16'd16;
	localparam logic [15:0] PERIOD_256  = 16'd256;

	typedef struct packed {
		logic tick;
		logic write;
		logic clr_pending;
	} chan_cmd_t;

	typedef struct packed {
		logic [7:0] counter;
		logic       pend_nxt;
		logic       vec_wr;
	} chan_stat_t;

endpackage

[hdl/four_channel_counter_timer_core.sv]
// ----------------------------------------------------------------------------
// four_channel_counter_timer_core
// Four-channel counter/timer in timer mode with a single interrupt request.
// ----------------------------------------------------------------------------
// Usage:
//   Input words carry command, channel, bus_data and tick_states: tick,
//   read counter, write byte or acknowledge interrupt.
//   Every input word yields exactly one output word: read_data (counter on
//   read, else zero), irq_request and irq_vector after that word.
//   An accepted word sits in the input register while all four channels
//   and the request update, and the result register takes it once the
//   output side is free.
//   Throughput is one word per cycle; a new word is taken each cycle while
//   the output side keeps up. All four channels update in parallel, which
//   sets this rate.
//   When out_stall is high the output word holds; an empty input register
//   still takes one more input word, then in_stall stays high until the
//   output word is taken.
//   Reset clears all channel state (channels running, counters zero) and
//   the interrupt request; no word is in flight after reset.
// ----------------------------------------------------------------------------
module four_channel_counter_timer_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] command,
	input  logic [1:0] channel,
	input  logic [7:0] bus_data,
	input  logic [7:0] tick_states,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] read_data,
	output logic       irq_request,
	output logic [7:0] irq_vector
);

	logic       valid_s1;
	logic [1:0] cmd_s1, ch_s1;
	logic [7:0] data_s1, states_s1;

	logic       out_valid_q;
	logic [7:0] read_data_q;
	logic       req_q;
	logic [7:0] vec_q;
	logic [4:0] vbase_q;

	logic       advance;
	logic       req_n;
	logic [7:0] vec_n;
	logic [fcct_pkg::NUM_CH-1:0] clr;

	fcct_pkg::chan_cmd_t  ccmd [fcct_pkg::NUM_CH];
	fcct_pkg::chan_stat_t cstat[fcct_pkg::NUM_CH];

	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && out_valid_q && out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall) begin
			cmd_s1    <= command;
			ch_s1     <= channel;
			data_s1   <= bus_data;
			states_s1 <= tick_states;
		end
	end

	// on a tick, raise the request from the lowest-numbered pending channel; clear it on acknowledge
	always_comb begin
		req_n = req_q;
		vec_n = vec_q;
		clr   = '0;
		if (advance && cmd_s1 == fcct_pkg::CMD_TICK) begin
			for (int i = 0; i < fcct_pkg::NUM_CH; i++) begin
				if (cstat[i].pend_nxt && !req_n) begin
					req_n  = 1'b1;
					vec_n  = {vbase_q, 2'(i), 1'b0};
					clr[i] = 1'b1;
				end
			end
		end
		if (advance && cmd_s1 == fcct_pkg::CMD_ACK) begin
			req_n = 1'b0;
		end
	end

	for (genvar g = 0; g < fcct_pkg::NUM_CH; g++) begin : g_ch
		assign ccmd[g].tick        = advance && cmd_s1 == fcct_pkg::CMD_TICK;
		assign ccmd[g].write       = advance && cmd_s1 == fcct_pkg::CMD_WRITE && ch_s1 == 2'(g);
		assign ccmd[g].clr_pending = clr[g];

		fcct_channel u_ch (
			.clk         (clk),
			.arst_n      (arst_n),
			.cmd         (ccmd[g]),
			.bus_data    (data_s1),
			.tick_states (states_s1),
			.stat        (cstat[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			req_q       <= 1'b0;
			vec_q       <= '0;
			vbase_q     <= '0;
		end else begin
			req_q <= req_n;
			vec_q <= vec_n;
			if (advance && cmd_s1 == fcct_pkg::CMD_WRITE && ch_s1 == 2'd0 && cstat[0].vec_wr) begin
				vbase_q <= data_s1[7:3];
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			read_data_q <= (cmd_s1 == fcct_pkg::CMD_READ) ? cstat[ch_s1].counter : 8'd0;
		end
	end

	assign out_valid   = out_valid_q;
	assign read_data   = read_data_q;
	assign irq_request = req_q;
	assign irq_vector  = vec_q;

endmodule

[hdl/fcct_channel.sv]
// ----------------------------------------------------------------------------
// fcct_channel
// One timer channel: control word, time constant, down counter, prescaler.
// ----------------------------------------------------------------------------
module fcct_channel (
	input  logic                   clk,
	input  logic                   arst_n,
	input  fcct_pkg::chan_cmd_t    cmd,
	input  logic [7:0]             bus_data,
	input  logic [7:0]             tick_states,
	output fcct_pkg::chan_stat_t   stat
);

	logic [7:0]  cw_q, tc_q, dc_q;
	logic [15:0] acc_q;
	logic        run_q, pend_q;

	logic [7:0]  cw_n, tc_n, dc_n, dec;
	logic [15:0] acc_n, sat, period;
	logic [16:0] sum;
	logic        run_n, pend_n;

	always_comb begin
		cw_n   = cw_q;
		tc_n   = tc_q;
		dc_n   = dc_q;
		acc_n  = acc_q;
		run_n  = run_q;
		pend_n = pend_q;
		sum    = {1'b0, acc_q} + {9'b0, tick_states};
		sat    = sum[16] ? fcct_pkg::ACCUM_MAX : sum[15:0];
		period = cw_q[fcct_pkg::CW_PRESCALE256] ? fcct_pkg::PERIOD_256 : fcct_pkg::PERIOD_16;
		dec    = dc_q - 8'd1;
		if (cmd.tick && run_q) begin
			if (cw_q[fcct_pkg::CW_SOFT_RESET]) begin
				acc_n = '0;
				cw_n[fcct_pkg::CW_SOFT_RESET] = 1'b0;
				run_n = 1'b0;
			end else if (!cw_q[fcct_pkg::CW_COUNTER_MODE]) begin
				if (sat >= period) begin
					acc_n = sat - period;
					if (dec == 8'd0) begin
						dc_n = tc_q;
						if (cw_q[fcct_pkg::CW_INT_ENABLE]) begin
							pend_n = 1'b1;
						end
					end else begin
						dc_n = dec;
					end
				end else begin
					acc_n = sat;
				end
			end
		end
		if (cmd.write) begin
			priority if (cw_q[fcct_pkg::CW_TC_FOLLOWS]) begin
				tc_n = bus_data;
				dc_n = bus_data;
				cw_n[fcct_pkg::CW_TC_FOLLOWS] = 1'b0;
				run_n = 1'b1;
			end else if (bus_data[fcct_pkg::CW_IS_CONTROL]) begin
				cw_n = bus_data;
			end else begin
				cw_n = cw_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cw_q   <= '0;
			tc_q   <= '0;
			dc_q   <= '0;
			acc_q  <= '0;
			run_q  <= 1'b1;
			pend_q <= 1'b0;
		end else begin
			cw_q   <= cw_n;
			tc_q   <= tc_n;
			dc_q   <= dc_n;
			acc_q  <= acc_n;
			run_q  <= run_n;
			pend_q <= pend_n && !cmd.clr_pending;
		end
	end

	assign stat.counter  = dc_q;
	assign stat.pend_nxt = pend_n;
	assign stat.vec_wr   = !cw_q[fcct_pkg::CW_TC_FOLLOWS] && !bus_data[fcct_pkg::CW_IS_CONTROL];

endmodule

[hdl/fcct_checker.sv]
// ----------------------------------------------------------------------------
// fcct_checker
// Port-level checks for the counter/timer core, bound to the top level.
// ----------------------------------------------------------------------------
`include "four_channel_counter_timer_core_defines.svh"

module fcct_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic [1:0] command,
	input logic [1:0] channel,
	input logic [7:0] bus_data,
	input logic [7:0] tick_states,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] read_data,
	input logic       irq_request,
	input logic [7:0] irq_vector
);

	`FCCT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(read_data) && $stable(irq_request) && $stable(irq_vector))
	`FCCT_ASSERT_NOW(a_no_stall_when_empty, !out_valid, !in_stall)
	`FCCT_ASSERT_NOW(a_vector_even, out_valid, !irq_vector[0])

endmodule

bind four_channel_counter_timer_core fcct_checker u_fcct_checker (.*);

[verif/tb_four_channel_counter_timer_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_four_channel_counter_timer_core
// Self-checking bench for the four-channel counter/timer core. A queue of
// command words (directed cases, then programmed-channel sequences, tick, read
// and acknowledge bursts, an accumulator saturation run and random noise) feeds
// a clocked driver. Each accepted word updates a timer model of the four
// channels, which queues the response word; a clocked monitor compares every
// output word field by field. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_four_channel_counter_timer_core;

	localparam int TOTAL_WORDS = 1175;
	localparam int CYCLE_LIMIT = 300000;

	typedef struct packed {
		logic [1:0] cmd;
		logic [1:0] ch;
		logic [7:0] data;
		logic [7:0] states;
		logic       drain_first;
	} bus_word_t;

	typedef struct packed {
		logic [7:0] rd;
		logic       req;
		logic [7:0] vec;
	} ctc_resp_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [1:0] command = fcct_pkg::CMD_TICK;
	logic [1:0] channel = 2'd0;
	logic [7:0] bus_data = 8'd0;
	logic [7:0] tick_states = 8'd0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] read_data;
	logic       irq_request;
	logic [7:0] irq_vector;

	four_channel_counter_timer_core uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.command     (command),
		.channel     (channel),
		.bus_data    (bus_data),
		.tick_states (tick_states),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.read_data   (read_data),
		.irq_request (irq_request),
		.irq_vector  (irq_vector)
	);

	always #1 clk = ~clk;

	// timer model state
	logic [7:0]  ctl_word     [fcct_pkg::NUM_CH];
	logic [7:0]  reload_val   [fcct_pkg::NUM_CH];
	logic [7:0]  down_cnt     [fcct_pkg::NUM_CH];
	logic [15:0] prescale_acc [fcct_pkg::NUM_CH];
	logic        chan_run     [fcct_pkg::NUM_CH];
	logic        chan_pend    [fcct_pkg::NUM_CH];
	logic [4:0]  vec_base;
	logic        irq_flag;
	logic [7:0]  irq_vec;

	bus_word_t word_q[$];
	ctc_resp_t resp_q[$];
	bus_word_t cur_word;
	ctc_resp_t resp_head;

	int  words_queued = 0;
	int  words_taken = 0;
	int  err_cnt = 0;
	int  cycle_cnt = 0;
	int  send_idle_pct = 32;
	int  recv_stall_pct = 70;
	logic drain_next = 1'b0;

	task automatic report_mismatch(input string msg);
		err_cnt++;
		if (err_cnt <= 200)
			$display("[%0t] mismatch: %s", $time, msg);
	endtask

	function automatic void tick_timer_chan(int ch, logic [7:0] states);
		logic [16:0] sum;
		logic [15:0] period;
		if (!chan_run[ch])
			return;
		if (ctl_word[ch][fcct_pkg::CW_SOFT_RESET]) begin
			prescale_acc[ch] = '0;
			ctl_word[ch][fcct_pkg::CW_SOFT_RESET] = 1'b0;
			chan_run[ch] = 1'b0;
			return;
		end
		if (ctl_word[ch][fcct_pkg::CW_COUNTER_MODE])
			return;
		period = ctl_word[ch][fcct_pkg::CW_PRESCALE256] ? fcct_pkg::PERIOD_256
			: fcct_pkg::PERIOD_16;
		sum = {1'b0, prescale_acc[ch]} + {9'd0, states};
		if (sum > {1'b0, fcct_pkg::ACCUM_MAX})
			sum = {1'b0, fcct_pkg::ACCUM_MAX};
		if (sum >= {1'b0, period}) begin
			sum = sum - {1'b0, period};
			down_cnt[ch] = down_cnt[ch] - 8'd1;
			if (down_cnt[ch] == 8'd0) begin
				down_cnt[ch] = reload_val[ch];
				if (ctl_word[ch][fcct_pkg::CW_INT_ENABLE])
					chan_pend[ch] = 1'b1;
			end
		end
		prescale_acc[ch] = sum[15:0];
	endfunction

	// advance the timer model by one word and queue its response
	function automatic void ctc_predict(bus_word_t w);
		ctc_resp_t r;
		logic [1:0] ci;
		r.rd = 8'd0;
		case (w.cmd)
			fcct_pkg::CMD_TICK: begin
				for (int i = 0; i < fcct_pkg::NUM_CH; i++) begin
					ci = i[1:0];
					tick_timer_chan(i, w.states);
					if (chan_pend[i] && !irq_flag) begin
						irq_flag = 1'b1;
						irq_vec = {vec_base, ci, 1'b0};
						chan_pend[i] = 1'b0;
					end
				end
			end
			fcct_pkg::CMD_READ: r.rd = down_cnt[w.ch];
			fcct_pkg::CMD_WRITE: begin
				if (ctl_word[w.ch][fcct_pkg::CW_TC_FOLLOWS]) begin
					reload_val[w.ch] = w.data;
					down_cnt[w.ch] = w.data;
					ctl_word[w.ch][fcct_pkg::CW_TC_FOLLOWS] = 1'b0;
					chan_run[w.ch] = 1'b1;
				end else if (w.data[fcct_pkg::CW_IS_CONTROL]) begin
					ctl_word[w.ch] = w.data;
				end else if (w.ch == 2'd0) begin
					vec_base = w.data[7:3];
				end
			end
			default: irq_flag = 1'b0;
		endcase
		r.req = irq_flag;
		r.vec = irq_vec;
		resp_q.push_back(r);
	endfunction

	task automatic push_word(input logic [1:0] cmd, input logic [1:0] ch,
			input logic [7:0] data, input logic [7:0] states);
		bus_word_t w;
		w.cmd = cmd;
		w.ch = ch;
		w.data = data;
		w.states = states;
		w.drain_first = drain_next;
		drain_next = 1'b0;
		word_q.push_back(w);
		words_queued++;
	endtask

	function automatic logic [7:0] pick_states();
		int r;
		r = $urandom_range(3);
		if (r == 0)
			return 8'($urandom_range(15));
		if (r == 1)
			return 8'($urandom_range(255, 240));
		return 8'($urandom_range(255));
	endfunction

	// driver
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				ctc_predict(cur_word);
				words_taken++;
			end
			if (!in_valid || !in_stall) begin
				if (word_q.size() != 0 && !(word_q[0].drain_first && resp_q.size() != 0)
						&& $urandom_range(99) >= send_idle_pct) begin
					cur_word = word_q.pop_front();
					in_valid <= 1'b1;
					command <= cur_word.cmd;
					channel <= cur_word.ch;
					bus_data <= cur_word.data;
					tick_states <= cur_word.states;
				end else begin
					in_valid <= 1'b0;
				end
			end
			if (words_taken >= 800) begin
				send_idle_pct <= 0;
				recv_stall_pct <= 0;
			end else if (words_taken >= 400) begin
				send_idle_pct <= 70;
				recv_stall_pct <= 32;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (resp_q.size() == 0) begin
					report_mismatch("output word with no response expected");
				end else begin
					resp_head = resp_q.pop_front();
					if (read_data !== resp_head.rd)
						report_mismatch($sformatf("read_data got %0h want %0h",
							read_data, resp_head.rd));
					if (irq_request !== resp_head.req)
						report_mismatch($sformatf("irq_request got %0b want %0b",
							irq_request, resp_head.req));
					if (irq_vector !== resp_head.vec)
						report_mismatch($sformatf("irq_vector got %0h want %0h",
							irq_vector, resp_head.vec));
				end
			end
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		int r;
		int n;
		int next_drain_at;
		logic sat_done;
		logic [1:0] ch;
		logic [7:0] cw;
		logic [7:0] data;

		for (int i = 0; i < fcct_pkg::NUM_CH; i++) begin
			ctl_word[i] = '0;
			reload_val[i] = '0;
			down_cnt[i] = '0;
			prescale_acc[i] = '0;
			chan_run[i] = 1'b1;
			chan_pend[i] = 1'b0;
		end
		vec_base = '0;
		irq_flag = 1'b0;
		irq_vec = '0;

		// directed: counter wrap from zero, vectors, interrupt flow,
		// counter mode, soft reset and restart, prescale 256
		push_word(fcct_pkg::CMD_READ, 2'd0, 8'hFF, 8'hFF);
		push_word(fcct_pkg::CMD_TICK, 2'd3, 8'h00, 8'd0);
		push_word(fcct_pkg::CMD_TICK, 2'd0, 8'hFF, 8'd255);
		push_word(fcct_pkg::CMD_WRITE, 2'd0, 8'hF8, 8'd0);
		push_word(fcct_pkg::CMD_WRITE, 2'd2, 8'hA8, 8'd0);
		push_word(fcct_pkg::CMD_WRITE, 2'd1, 8'h85, 8'd0);
		push_word(fcct_pkg::CMD_WRITE, 2'd1, 8'h01, 8'd0);
		push_word(fcct_pkg::CMD_TICK, 2'd0, 8'h00, 8'd16);
		push_word(fcct_pkg::CMD_TICK, 2'd0, 8'h00, 8'd16);
		push_word(fcct_pkg::CMD_ACK, 2'd0, 8'h00, 8'd0);
		push_word(fcct_pkg::CMD_TICK, 2'd0, 8'h00, 8'd0);
		push_word(fcct_pkg::CMD_READ, 2'd1, 8'h00, 8'd0);
		push_word(fcct_pkg::CMD_WRITE, 2'd2, 8'h45, 8'd0);
		push_word(fcct_pkg::CMD_WRITE, 2'd2, 8'h00, 8'd0);
		push_word(fcct_pkg::CMD_TICK, 2'd0, 8'h00, 8'd255);
		push_word(fcct_pkg::CMD_READ, 2'd2, 8'h00, 8'd0);
		push_word(fcct_pkg::CMD_WRITE, 2'd3, 8'h03, 8'd0);
		push_word(fcct_pkg::CMD_TICK, 2'd0, 8'h00, 8'd8);
		push_word(fcct_pkg::CMD_TICK, 2'd0, 8'h00, 8'd255);
		push_word(fcct_pkg::CMD_READ, 2'd3, 8'h00, 8'd0);
		push_word(fcct_pkg::CMD_WRITE, 2'd3, 8'h25, 8'd0);
		push_word(fcct_pkg::CMD_WRITE, 2'd3, 8'hFF, 8'd0);
		push_word(fcct_pkg::CMD_TICK, 2'd0, 8'h00, 8'd255);
		push_word(fcct_pkg::CMD_TICK, 2'd0, 8'h00, 8'd255);
		push_word(fcct_pkg::CMD_READ, 2'd3, 8'h00, 8'd0);
		push_word(fcct_pkg::CMD_ACK, 2'd0, 8'h00, 8'd0);
		push_word(fcct_pkg::CMD_ACK, 2'd2, 8'hFF, 8'hFF);

		next_drain_at = 100;
		sat_done = 1'b0;
		while (words_queued < TOTAL_WORDS) begin
			if (words_queued >= next_drain_at) begin
				drain_next = 1'b1;
				next_drain_at += 300;
			end
			if (!sat_done && words_queued > 450) begin
				// force channel 0 to a known control word, then saturate its prescaler
				push_word(fcct_pkg::CMD_WRITE, 2'd0, 8'h01, pick_states());
				push_word(fcct_pkg::CMD_WRITE, 2'd0, 8'h85, pick_states());
				push_word(fcct_pkg::CMD_WRITE, 2'd0, 8'h80, pick_states());
				for (int k = 0; k < 300; k++)
					push_word(fcct_pkg::CMD_TICK, 2'($urandom_range(3)),
						8'($urandom_range(255)), 8'd255);
				sat_done = 1'b1;
				continue;
			end
			r = $urandom_range(99);
			if (r < 30) begin
				ch = 2'($urandom_range(3));
				cw = 8'($urandom_range(255));
				cw[fcct_pkg::CW_IS_CONTROL] = 1'b1;
				cw[fcct_pkg::CW_TC_FOLLOWS] = ($urandom_range(9) < 8);
				cw[fcct_pkg::CW_SOFT_RESET] = ($urandom_range(9) == 0);
				cw[fcct_pkg::CW_COUNTER_MODE] = ($urandom_range(9) == 0);
				cw[fcct_pkg::CW_INT_ENABLE] = ($urandom_range(9) < 7);
				push_word(fcct_pkg::CMD_WRITE, ch, cw, pick_states());
				if (cw[fcct_pkg::CW_TC_FOLLOWS]) begin
					data = ($urandom_range(3) == 0) ? 8'($urandom_range(255))
						: 8'($urandom_range(6, 1));
					push_word(fcct_pkg::CMD_WRITE, ch, data, pick_states());
				end
			end else if (r < 80) begin
				n = $urandom_range(10, 1);
				for (int k = 0; k < n; k++) begin
					r = $urandom_range(99);
					ch = 2'($urandom_range(3));
					data = 8'($urandom_range(255));
					if (r < 60)
						push_word(fcct_pkg::CMD_TICK, ch, data, pick_states());
					else if (r < 80)
						push_word(fcct_pkg::CMD_READ, ch, data, pick_states());
					else
						push_word(fcct_pkg::CMD_ACK, ch, data, pick_states());
				end
			end else if (r < 85) begin
				ch = ($urandom_range(3) == 0) ? 2'($urandom_range(3)) : 2'd0;
				data = 8'($urandom_range(255));
				data[fcct_pkg::CW_IS_CONTROL] = 1'b0;
				push_word(fcct_pkg::CMD_WRITE, ch, data, pick_states());
			end else begin
				push_word(2'($urandom_range(3)), 2'($urandom_range(3)),
					8'($urandom_range(255)), 8'($urandom_range(255)));
			end
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		while (word_q.size() != 0 || words_taken != words_queued)
			@(posedge clk);
		while (resp_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (err_cnt == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

[four_channel_counter_timer_core.f]
+incdir+hdl
hdl/fcct_pkg.sv
hdl/fcct_channel.sv
hdl/four_channel_counter_timer_core.sv
hdl/fcct_checker.sv
verif/tb_four_channel_counter_timer_core.sv
